/* hdl/obb_2d_overlap_test_unit_macros.svh */
// Assertion macros for the oriented box overlap test unit.
// Expects clk and arst_n in the scope of use.
`ifndef OBB_2D_OVERLAP_TEST_UNIT_MACROS_SVH
`define OBB_2D_OVERLAP_TEST_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define OBB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define OBB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/obb_ovl_pkg.sv */
// Shared widths, types and helpers for the oriented box overlap test.
// No dependencies.
package obb_ovl_pkg;

	localparam int unsigned CW        = 24;
	localparam int unsigned NAXIS     = 4;
	localparam int unsigned NPAIR     = NAXIS * (NAXIS + 1) / 2;
	localparam int unsigned NFIELD    = 12;
	localparam int unsigned S_TDATA_W = ((NFIELD * CW + 7) / 8) * 8;
	localparam int unsigned AXIS_W    = 3;
	localparam int unsigned M_TDATA_W = 8;

	// input field order inside s_tdata
	localparam int unsigned F_LCX = 0;
	localparam int unsigned F_LCY = 1;
	localparam int unsigned F_LAX = 2;
	localparam int unsigned F_LAY = 3;
	localparam int unsigned F_LBX = 4;
	localparam int unsigned F_LBY = 5;
	localparam int unsigned F_RCX = 6;
	localparam int unsigned F_RCY = 7;
	localparam int unsigned F_RAX = 8;
	localparam int unsigned F_RAY = 9;
	localparam int unsigned F_RBX = 10;
	localparam int unsigned F_RBY = 11;

	typedef logic signed [CW-1:0]     coord_t;
	typedef logic signed [CW:0]       diff_t;
	typedef logic signed [2*CW-1:0]   eprod_t;
	typedef logic signed [2*CW:0]     dprod_t;
	typedef logic signed [2*CW+1:0]   dot_t;
	typedef logic        [2*CW+1:0]   mag_t;
	typedef logic        [AXIS_W-1:0] axis_t;

	localparam axis_t AXIS_NONE = axis_t'(NAXIS);

	// slot of the unordered edge pair (a, b) in the triangular list
	function automatic int unsigned pair_idx(input int unsigned a, input int unsigned b);
		int unsigned lo;
		int unsigned hi;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		return lo * NAXIS - ((lo * (lo - 1)) >> 1) + hi - lo;
	endfunction

endpackage

/* hdl/obb_ovl_dot.sv */
// Products and dot-product magnitudes (stages 2 and 3).
// Depends on obb_ovl_pkg.
module obb_ovl_dot (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  valid_s1,
	input  obb_ovl_pkg::coord_t   edge_x_s1 [obb_ovl_pkg::NAXIS],
	input  obb_ovl_pkg::coord_t   edge_y_s1 [obb_ovl_pkg::NAXIS],
	input  obb_ovl_pkg::diff_t    dx_s1,
	input  obb_ovl_pkg::diff_t    dy_s1,
	output logic                  ready_up,
	input  logic                  ready_down,
	output logic                  valid_s3,
	output obb_ovl_pkg::mag_t     ee_mag_s3 [obb_ovl_pkg::NPAIR],
	output obb_ovl_pkg::mag_t     ed_mag_s3 [obb_ovl_pkg::NAXIS]
);

	logic                en2;
	logic                en3;
	logic                valid_s2;
	obb_ovl_pkg::eprod_t eex_s2 [obb_ovl_pkg::NPAIR];
	obb_ovl_pkg::eprod_t eey_s2 [obb_ovl_pkg::NPAIR];
	obb_ovl_pkg::dprod_t edx_s2 [obb_ovl_pkg::NAXIS];
	obb_ovl_pkg::dprod_t edy_s2 [obb_ovl_pkg::NAXIS];
	obb_ovl_pkg::mag_t   ee_mag [obb_ovl_pkg::NPAIR];
	obb_ovl_pkg::mag_t   ed_mag [obb_ovl_pkg::NAXIS];

	assign en3      = !valid_s3 || ready_down;
	assign en2      = !valid_s2 || en3;
	assign ready_up = en2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en2) begin
				valid_s2 <= valid_s1;
			end
			if (en3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	// edge-edge products, one per unordered pair
	for (genvar i = 0; i < obb_ovl_pkg::NAXIS; i++) begin : g_row
		for (genvar j = i; j < obb_ovl_pkg::NAXIS; j++) begin : g_col
			localparam int unsigned P = obb_ovl_pkg::pair_idx(i, j);
			always_ff @(posedge clk) begin
				if (en2 && valid_s1) begin
					eex_s2[P] <= obb_ovl_pkg::eprod_t'(edge_x_s1[i])
						* obb_ovl_pkg::eprod_t'(edge_x_s1[j]);
					eey_s2[P] <= obb_ovl_pkg::eprod_t'(edge_y_s1[i])
						* obb_ovl_pkg::eprod_t'(edge_y_s1[j]);
				end
			end
		end
	end

	// edge-offset products
	for (genvar i = 0; i < obb_ovl_pkg::NAXIS; i++) begin : g_off
		always_ff @(posedge clk) begin
			if (en2 && valid_s1) begin
				edx_s2[i] <= obb_ovl_pkg::dprod_t'(edge_x_s1[i]) * obb_ovl_pkg::dprod_t'(dx_s1);
				edy_s2[i] <= obb_ovl_pkg::dprod_t'(edge_y_s1[i]) * obb_ovl_pkg::dprod_t'(dy_s1);
			end
		end
	end

	always_comb begin
		obb_ovl_pkg::dot_t t;
		for (int p = 0; p < obb_ovl_pkg::NPAIR; p++) begin
			t = obb_ovl_pkg::dot_t'(eex_s2[p]) + obb_ovl_pkg::dot_t'(eey_s2[p]);
			ee_mag[p] = t[$bits(t)-1] ? obb_ovl_pkg::mag_t'(-t) : obb_ovl_pkg::mag_t'(t);
		end
		for (int i = 0; i < obb_ovl_pkg::NAXIS; i++) begin
			t = obb_ovl_pkg::dot_t'(edx_s2[i]) + obb_ovl_pkg::dot_t'(edy_s2[i]);
			ed_mag[i] = t[$bits(t)-1] ? obb_ovl_pkg::mag_t'(-t) : obb_ovl_pkg::mag_t'(t);
		end
	end

	always_ff @(posedge clk) begin
		if (en3 && valid_s2) begin
			ee_mag_s3 <= ee_mag;
			ed_mag_s3 <= ed_mag;
		end
	end

endmodule

/* hdl/obb_ovl_sep.sv */
// Per-axis projection sums, separation compare and axis encode (stages 4 and 5).
// Depends on obb_ovl_pkg.
module obb_ovl_sep (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 valid_s3,
	input  obb_ovl_pkg::mag_t    ee_mag_s3 [obb_ovl_pkg::NPAIR],
	input  obb_ovl_pkg::mag_t    ed_mag_s3 [obb_ovl_pkg::NAXIS],
	output logic                 ready_up,
	input  logic                 ready_down,
	output logic                 valid_s5,
	output logic                 overlaps_s5,
	output obb_ovl_pkg::axis_t   axis_s5
);

	logic                                en4;
	logic                                en5;
	logic                                valid_s4;
	obb_ovl_pkg::mag_t                   sum [obb_ovl_pkg::NAXIS];
	obb_ovl_pkg::mag_t                   sum_s4 [obb_ovl_pkg::NAXIS];
	obb_ovl_pkg::mag_t                   c2_s4 [obb_ovl_pkg::NAXIS];
	logic [obb_ovl_pkg::NAXIS-1:0]       sep;
	obb_ovl_pkg::axis_t                  axis;

	assign en5      = !valid_s5 || ready_down;
	assign en4      = !valid_s4 || en5;
	assign ready_up = en4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (en4) begin
				valid_s4 <= valid_s3;
			end
			if (en5) begin
				valid_s5 <= valid_s4;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < obb_ovl_pkg::NAXIS; i++) begin
			sum[i] = '0;
			for (int j = 0; j < obb_ovl_pkg::NAXIS; j++) begin
				sum[i] = sum[i] + ee_mag_s3[obb_ovl_pkg::pair_idx(i, j)];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en4 && valid_s3) begin
			sum_s4 <= sum;
			for (int i = 0; i < obb_ovl_pkg::NAXIS; i++) begin
				c2_s4[i] <= ed_mag_s3[i] << 1;
			end
		end
	end

	// lowest separating axis wins
	always_comb begin
		axis = obb_ovl_pkg::AXIS_NONE;
		for (int i = 0; i < obb_ovl_pkg::NAXIS; i++) begin
			sep[i] = sum_s4[i] < c2_s4[i];
		end
		for (int i = obb_ovl_pkg::NAXIS - 1; i >= 0; i--) begin
			if (sep[i]) begin
				axis = obb_ovl_pkg::axis_t'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en5 && valid_s4) begin
			overlaps_s5 <= ~|sep;
			axis_s5     <= axis;
		end
	end

endmodule

/* hdl/obb_2d_overlap_test_unit.sv */
// Channel   Dir  Fields
// s_axis    in   12 box coordinates, signed Q15.8, packed in s_tdata
// m_axis    out  overlaps, separating_axis, packed in m_tdata
//
// One pair per cycle while the output side is not stalled. Stages: input register and offset subtract,
// multipliers, dot sums with magnitude, projection sums, compare and encode.
// Reset clears only the stage valid bits.
// Each stage holds while its successor is full and blocked; a bubble frees its
// upstream neighbor, so stalls lose or repeat no transfer.
// Depends on obb_ovl_pkg, obb_ovl_dot, obb_ovl_sep and the macros header.
`include "obb_2d_overlap_test_unit_macros.svh"

module obb_2d_overlap_test_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// low to high: left_center_x, left_center_y, left_edge_a_x, left_edge_a_y,
	// left_edge_b_x, left_edge_b_y, right_center_x, right_center_y,
	// right_edge_a_x, right_edge_a_y, right_edge_b_x, right_edge_b_y
	input  logic [obb_ovl_pkg::S_TDATA_W-1:0]   s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// low to high: overlaps, separating_axis[2:0], zero pad
	output logic [obb_ovl_pkg::M_TDATA_W-1:0]   m_tdata
);

	logic                 en1;
	logic                 valid_s1;
	logic                 dot_ready;
	logic                 sep_ready;
	logic                 valid_s3;
	logic                 overlaps_s5;
	obb_ovl_pkg::axis_t   axis_s5;
	obb_ovl_pkg::coord_t  edge_x_s1 [obb_ovl_pkg::NAXIS];
	obb_ovl_pkg::coord_t  edge_y_s1 [obb_ovl_pkg::NAXIS];
	obb_ovl_pkg::diff_t   dx_s1;
	obb_ovl_pkg::diff_t   dy_s1;
	obb_ovl_pkg::mag_t    ee_mag_s3 [obb_ovl_pkg::NPAIR];
	obb_ovl_pkg::mag_t    ed_mag_s3 [obb_ovl_pkg::NAXIS];

	function automatic obb_ovl_pkg::coord_t fld(input int unsigned k,
			input logic [obb_ovl_pkg::S_TDATA_W-1:0] d);
		return d[k*obb_ovl_pkg::CW +: obb_ovl_pkg::CW];
	endfunction

	assign en1      = !valid_s1 || dot_ready;
	assign s_tready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en1) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && s_tvalid) begin
			edge_x_s1[0] <= fld(obb_ovl_pkg::F_LAX, s_tdata);
			edge_y_s1[0] <= fld(obb_ovl_pkg::F_LAY, s_tdata);
			edge_x_s1[1] <= fld(obb_ovl_pkg::F_LBX, s_tdata);
			edge_y_s1[1] <= fld(obb_ovl_pkg::F_LBY, s_tdata);
			edge_x_s1[2] <= fld(obb_ovl_pkg::F_RAX, s_tdata);
			edge_y_s1[2] <= fld(obb_ovl_pkg::F_RAY, s_tdata);
			edge_x_s1[3] <= fld(obb_ovl_pkg::F_RBX, s_tdata);
			edge_y_s1[3] <= fld(obb_ovl_pkg::F_RBY, s_tdata);
			dx_s1 <= obb_ovl_pkg::diff_t'(fld(obb_ovl_pkg::F_LCX, s_tdata))
				- obb_ovl_pkg::diff_t'(fld(obb_ovl_pkg::F_RCX, s_tdata));
			dy_s1 <= obb_ovl_pkg::diff_t'(fld(obb_ovl_pkg::F_LCY, s_tdata))
				- obb_ovl_pkg::diff_t'(fld(obb_ovl_pkg::F_RCY, s_tdata));
		end
	end

	obb_ovl_dot u_dot (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s1   (valid_s1),
		.edge_x_s1  (edge_x_s1),
		.edge_y_s1  (edge_y_s1),
		.dx_s1      (dx_s1),
		.dy_s1      (dy_s1),
		.ready_up   (dot_ready),
		.ready_down (sep_ready),
		.valid_s3   (valid_s3),
		.ee_mag_s3  (ee_mag_s3),
		.ed_mag_s3  (ed_mag_s3)
	);

	obb_ovl_sep u_sep (
		.clk         (clk),
		.arst_n      (arst_n),
		.valid_s3    (valid_s3),
		.ee_mag_s3   (ee_mag_s3),
		.ed_mag_s3   (ed_mag_s3),
		.ready_up    (sep_ready),
		.ready_down  (m_tready),
		.valid_s5    (m_tvalid),
		.overlaps_s5 (overlaps_s5),
		.axis_s5     (axis_s5)
	);

	assign m_tdata = {(obb_ovl_pkg::M_TDATA_W - obb_ovl_pkg::AXIS_W - 1)'(0),
		axis_s5, overlaps_s5};

	`OBB_ASSERT_NOW(a_result_consistent, m_tvalid, (overlaps_s5 == (axis_s5 == obb_ovl_pkg::AXIS_NONE)) && (axis_s5 <= obb_ovl_pkg::AXIS_NONE), "overlap flag and axis disagree")
	`OBB_ASSERT_NOW(a_stall_only_blocked, !s_tready, m_tvalid && !m_tready, "input stalled while output side is free")

endmodule

/* verif/tb_top.sv */
// Stream-level testbench for obb_2d_overlap_test_unit: box pairs go in, overlap verdicts come out.
// The expected verdicts are predicted in place from exact 64-bit projections.
// Depends on obb_ovl_pkg and the unit itself.
`timescale 1ns / 1ps

module tb_top;

	localparam int COORD_MIN = -8388608;
	localparam int COORD_MAX = 8388607;
	localparam int Q8_ONE    = 256;

	// first member lands in the top bits, so lcx ends up at bit 0
	typedef struct packed {
		obb_ovl_pkg::coord_t rby, rbx, ray, rax, rcy, rcx;
		obb_ovl_pkg::coord_t lby, lbx, lay, lax, lcy, lcx;
	} box_pair_t;

	typedef struct packed {
		obb_ovl_pkg::axis_t sep_axis;
		logic               overlaps;
	} verdict_t;

	typedef enum int {RX_ALWAYS, RX_COIN, RX_PATTERN} rx_mode_t;

	logic                              clk;
	logic                              arst_n;
	logic                              s_tvalid;
	logic                              s_tready;
	logic [obb_ovl_pkg::S_TDATA_W-1:0] s_tdata;
	logic                              m_tvalid;
	logic                              m_tready;
	logic [obb_ovl_pkg::M_TDATA_W-1:0] m_tdata;

	verdict_t verdict_q[$];
	int       error_count    = 0;
	int       sent_count     = 0;
	int       checked_count  = 0;
	int       stalled_offers = 0;
	int       axis_hits[5]   = '{default: 0};

	int       burst_left  = 0;
	int       max_gap     = 0;
	int       max_burst   = 16;
	rx_mode_t rx_mode     = RX_ALWAYS;
	int       rx_ready_pct = 100;
	logic [15:0] rx_mask  = 16'hffff;
	int       hold_cycles = 0;

	obb_2d_overlap_test_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#(64'd20_000_000);
		$display("[obb_2d_overlap_test_unit] ERROR");
		$finish;
	end

	function automatic longint mag(input longint v);
		return (v < 0) ? -v : v;
	endfunction

	// separating-axis verdict: first edge axis whose projected reach is below twice the
	// projected center distance
	function automatic verdict_t sat_verdict(input box_pair_t p);
		longint   ex[4];
		longint   ey[4];
		longint   dx;
		longint   dy;
		longint   reach;
		longint   gap2;
		int       i;
		int       j;
		verdict_t v;
		ex[0] = longint'(p.lax);  ey[0] = longint'(p.lay);
		ex[1] = longint'(p.lbx);  ey[1] = longint'(p.lby);
		ex[2] = longint'(p.rax);  ey[2] = longint'(p.ray);
		ex[3] = longint'(p.rbx);  ey[3] = longint'(p.rby);
		dx = longint'(p.lcx) - longint'(p.rcx);
		dy = longint'(p.lcy) - longint'(p.rcy);
		v.overlaps = 1'b1;
		v.sep_axis = obb_ovl_pkg::AXIS_NONE;
		for (i = 0; i < 4; i++) begin
			gap2 = 2 * mag(ex[i] * dx + ey[i] * dy);
			reach = 0;
			for (j = 0; j < 4; j++)
				reach += mag(ex[i] * ex[j] + ey[i] * ey[j]);
			if (reach < gap2) begin
				v.overlaps = 1'b0;
				v.sep_axis = obb_ovl_pkg::axis_t'(i);
				return v;
			end
		end
		return v;
	endfunction

	function automatic box_pair_t mk_pair(input int lcx, lcy, lax, lay, lbx, lby,
			input int rcx, rcy, rax, ray, rbx, rby);
		box_pair_t p;
		p.lcx = obb_ovl_pkg::coord_t'(lcx);  p.lcy = obb_ovl_pkg::coord_t'(lcy);
		p.lax = obb_ovl_pkg::coord_t'(lax);  p.lay = obb_ovl_pkg::coord_t'(lay);
		p.lbx = obb_ovl_pkg::coord_t'(lbx);  p.lby = obb_ovl_pkg::coord_t'(lby);
		p.rcx = obb_ovl_pkg::coord_t'(rcx);  p.rcy = obb_ovl_pkg::coord_t'(rcy);
		p.rax = obb_ovl_pkg::coord_t'(rax);  p.ray = obb_ovl_pkg::coord_t'(ray);
		p.rbx = obb_ovl_pkg::coord_t'(rbx);  p.rby = obb_ovl_pkg::coord_t'(rby);
		return p;
	endfunction

	// signed value in [-2^k, 2^k - 1], k <= 23
	function automatic obb_ovl_pkg::coord_t rand_coord(input int k);
		return obb_ovl_pkg::coord_t'(int'($urandom_range(0, (1 << (k + 1)) - 1)) - (1 << k));
	endfunction

	// mostly boxes of matching scale with nearby centers, so that every axis and
	// overlap show up; the rest is full-range noise or boxes with collapsed edges
	function automatic box_pair_t shaped_pair();
		box_pair_t p;
		int        roll;
		int        k;
		int        kr;
		roll = $urandom_range(0, 99);
		if (roll < 12) begin
			p = box_pair_t'({$urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom});
			return p;
		end
		k  = $urandom_range(2, 21);
		kr = k + $urandom_range(0, 4) - 2;
		if (kr > 21)
			kr = 21;
		p.lax = rand_coord(k);   p.lay = rand_coord(k);
		p.lbx = rand_coord(k);   p.lby = rand_coord(k);
		p.rax = rand_coord(kr);  p.ray = rand_coord(kr);
		p.rbx = rand_coord(kr);  p.rby = rand_coord(kr);
		p.lcx = rand_coord(22);  p.lcy = rand_coord(22);
		p.rcx = p.lcx + rand_coord(k + 1);
		p.rcy = p.lcy + rand_coord(k + 1);
		if (roll < 20) begin
			if ($urandom_range(0, 1)) begin p.lax = '0; p.lay = '0; end
			if ($urandom_range(0, 1)) begin p.lbx = '0; p.lby = '0; end
			if ($urandom_range(0, 1)) begin p.rax = '0; p.ray = '0; end
			if ($urandom_range(0, 1)) begin p.rbx = '0; p.rby = '0; end
		end
		return p;
	endfunction

	// one transfer on the input side, with burst/gap idling in front of it
	task automatic send_pair(input box_pair_t p);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, max_gap);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, max_burst);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= p;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		verdict_q.push_back(sat_verdict(p));
		sent_count++;
		burst_left--;
	endtask

	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (verdict_q.size() != 0);
	endtask

	task automatic test_field_extremes();
		send_pair(mk_pair(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
			COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
		send_pair(mk_pair(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
			COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
		send_pair(mk_pair(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
			COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
		send_pair(mk_pair(COORD_MIN, COORD_MAX, 1, 0, 0, 1,
			COORD_MAX, COORD_MIN, -1, 0, 0, -1));
		send_pair(mk_pair(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX,
			COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN));
		send_pair(box_pair_t'({36{8'haa}}));
		send_pair(box_pair_t'({36{8'h55}}));
		wait_for_results();
	endtask

	task automatic test_axis_order();
		// unit squares side by side: each case leaves the earlier axes blind
		send_pair(mk_pair(1000 * Q8_ONE, 0, Q8_ONE, 0, 0, Q8_ONE,
			0, 0, Q8_ONE, 0, 0, Q8_ONE));
		send_pair(mk_pair(0, 1000 * Q8_ONE, Q8_ONE, 0, 0, Q8_ONE,
			0, 0, Q8_ONE, 0, 0, Q8_ONE));
		send_pair(mk_pair(1000 * Q8_ONE, 0, 0, 0, 0, 0,
			0, 0, Q8_ONE, 0, 0, Q8_ONE));
		send_pair(mk_pair(0, 1000 * Q8_ONE, 0, 0, 0, 0,
			0, 0, 0, 0, 0, Q8_ONE));
		send_pair(mk_pair(5, -7, Q8_ONE, 0, 0, Q8_ONE,
			5, -7, 181, 181, -181, 181));
		wait_for_results();
	endtask

	task automatic test_special_cases();
		// touching on axis 0: reach equals twice the distance, no separation
		send_pair(mk_pair(Q8_ONE, 0, Q8_ONE, 0, 0, Q8_ONE,
			0, 0, Q8_ONE, 0, 0, Q8_ONE));
		send_pair(mk_pair(Q8_ONE + 1, 0, Q8_ONE, 0, 0, Q8_ONE,
			0, 0, Q8_ONE, 0, 0, Q8_ONE));
		send_pair(mk_pair(0, 0, Q8_ONE, 0, 0, Q8_ONE,
			Q8_ONE + 1, 0, Q8_ONE, 0, 0, Q8_ONE));
		// zero-length edges on every axis, far apart
		send_pair(mk_pair(COORD_MAX, COORD_MAX, 0, 0, 0, 0,
			COORD_MIN, COORD_MIN, 0, 0, 0, 0));
		// degenerate boxes with parallel edges
		send_pair(mk_pair(0, 0, Q8_ONE, Q8_ONE, 2 * Q8_ONE, 2 * Q8_ONE,
			3 * Q8_ONE, -3 * Q8_ONE, -Q8_ONE, -Q8_ONE, Q8_ONE, Q8_ONE));
		send_pair(mk_pair(0, 0, Q8_ONE, Q8_ONE, 2 * Q8_ONE, 2 * Q8_ONE,
			Q8_ONE, Q8_ONE, -Q8_ONE, -Q8_ONE, Q8_ONE, Q8_ONE));
		wait_for_results();
	endtask

	task automatic test_random_stream(input int n, input rx_mode_t mode, input int gap,
			input int burst, input int ready_pct);
		rx_mode      = mode;
		rx_ready_pct = ready_pct;
		rx_mask      = 16'($urandom) | 16'h0101;
		max_gap      = gap;
		max_burst    = burst;
		repeat (n) send_pair(shaped_pair());
		wait_for_results();
	endtask

	// receiver holds off long enough for the pipeline to fill and push back
	task automatic test_backpressure();
		rx_mode     = RX_ALWAYS;
		max_gap     = 0;
		max_burst   = 1000;
		hold_cycles = 300;
		repeat (60) send_pair(shaped_pair());
		wait_for_results();
	endtask

	// receiver: own stall pattern, plus an occasional long hold-off
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles != 0) begin
				m_tready <= 1'b0;
				repeat (hold_cycles - 1) @(posedge clk);
				hold_cycles = 0;
			end else begin
				case (rx_mode)
					RX_ALWAYS: m_tready <= 1'b1;
					RX_COIN:   m_tready <= ($urandom_range(0, 99) < rx_ready_pct);
					RX_PATTERN: begin
						rx_mask = {rx_mask[14:0], rx_mask[15]};
						m_tready <= rx_mask[0];
					end
				endcase
			end
		end
	end

	always @(posedge clk) begin
		verdict_t got;
		verdict_t want;
		if (arst_n && s_tvalid && !s_tready)
			stalled_offers++;
		if (arst_n && m_tvalid && m_tready) begin
			got = verdict_t'(m_tdata[3:0]);
			if (verdict_q.size() == 0) begin
				error_count++;
				$display("%0t: unexpected transfer, got overlaps=%0d axis=%0d",
					$time, got.overlaps, got.sep_axis);
			end else begin
				want = verdict_q.pop_front();
				checked_count++;
				if (want.sep_axis <= obb_ovl_pkg::AXIS_NONE)
					axis_hits[want.sep_axis]++;
				if (got.overlaps !== want.overlaps) begin
					error_count++;
					$display("%0t: overlaps mismatch, expected %0d, actual %0d",
						$time, want.overlaps, got.overlaps);
				end
				if (got.sep_axis !== want.sep_axis) begin
					error_count++;
					$display("%0t: separating_axis mismatch, expected %0d, actual %0d",
						$time, want.sep_axis, got.sep_axis);
				end
			end
		end
	end

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		max_gap   = 3;
		max_burst = 6;
		test_field_extremes();
		test_axis_order();
		test_special_cases();
		test_random_stream(450, RX_ALWAYS, 0, 64, 100);
		test_random_stream(450, RX_COIN, 5, 24, 70);
		test_random_stream(450, RX_PATTERN, 3, 40, 100);
		test_random_stream(400, RX_COIN, 8, 12, 30);
		test_backpressure();

		repeat (16) @(posedge clk);
		$display("run: %0d box pairs sent, %0d verdicts checked, %0d stalled offers",
			sent_count, checked_count, stalled_offers);
		$display("verdicts: axis0=%0d axis1=%0d axis2=%0d axis3=%0d overlap=%0d",
			axis_hits[0], axis_hits[1], axis_hits[2], axis_hits[3], axis_hits[4]);
		if (error_count == 0 && verdict_q.size() == 0)
			$display("[obb_2d_overlap_test_unit] OK");
		else
			$display("[obb_2d_overlap_test_unit] ERROR");
		$finish;
	end

endmodule
